@@ src/tws_pkg.sv @@
// Package with the shared types and constants of the trimmed window smoke filter.
`default_nettype none
package tws_pkg;

    localparam int SAMPLE_W = 12;
    localparam int OBS_W    = 16;
    localparam int BIAS_W   = 15;
    localparam int SCALE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [SAMPLE_W-1:0] LEVEL_MAX = 12'd4095;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OBS_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_MAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NEG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_SCALE  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_TACC  = 8'b0000_0100,
        S_LEVEL = 8'b0000_1000,
        S_DEL   = 8'b0001_0000,
        S_BIAS  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic load;
        logic tacc;
        logic level;
        logic del;
        logic bias;
        logic div;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic will_fill;
        logic tacc_last;
        logic div_last;
        logic obs_en;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

@@ src/tws_sample_if.sv @@
// Interface that carries one smoke sample item.
`default_nettype none
interface tws_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ src/tws_result_if.sv @@
// Interface that carries one filter result item.
`default_nettype none
interface tws_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] smoke_level;
    logic [15:0] obs_value;

    modport source (output valid, output smoke_level, output obs_value, input ready);
    modport sink (input valid, input smoke_level, input obs_value, output ready);
endinterface
`default_nettype wire

@@ src/tws_ram.sv @@
// Generic single write port RAM with a registered read port.
`default_nettype none
module tws_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/tws_ctrl.sv @@
// Controller state machine that sequences one sample item through the datapath.
`default_nettype none
module tws_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tws_pkg::sts_t sts,
    output tws_pkg::cmd_t      cmd
);
    import tws_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.insert = 1'b1;
                    if (sts.will_fill)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = S_TACC;
            end
            S_TACC:
            begin
                cmd.tacc = 1'b1;
                if (sts.tacc_last)
                begin
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                cmd.level = 1'b1;
                state_next = S_DEL;
            end
            S_DEL:
            begin
                cmd.del = 1'b1;
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                cmd.bias = 1'b1;
                state_next = sts.obs_en ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/tws_dp.sv @@
// Datapath: sample FIFO, sorted cells, trim sums, bias and serial divider.
`default_nettype none
module tws_dp #(
    parameter int TRIM      = 4,
    parameter int KEPT_LOG2 = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [tws_pkg::SAMPLE_W-1:0]      sample,
    input  wire logic                              cfg_we,
    input  wire logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire tws_pkg::cmd_t                     cmd,
    output tws_pkg::sts_t                          sts,
    tws_result_if.source                           results
);
    import tws_pkg::*;

    localparam int WIN   = 2 * TRIM + (1 << KEPT_LOG2);
    localparam int A_W   = $clog2(WIN);
    localparam int TOT_W = SAMPLE_W + $clog2(WIN + 1);
    localparam int TLEN  = (TRIM == 0) ? 1 : 2 * TRIM;
    localparam int K_W   = (TLEN > 1) ? $clog2(TLEN) : 1;

    // Configuration registers.
    logic               obs_enable_reg;
    logic [BIAS_W-1:0]  bias_mag_reg;
    logic               bias_neg_reg;
    logic [SCALE_W-1:0] obs_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_enable_reg <= 1'b0;
            bias_mag_reg   <= '0;
            bias_neg_reg   <= 1'b0;
            obs_scale_reg  <= SCALE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OBS_ENABLE: obs_enable_reg <= cfg_data[0];
                REG_BIAS_MAG:   bias_mag_reg   <= cfg_data[BIAS_W-1:0];
                REG_BIAS_NEG:   bias_neg_reg   <= cfg_data[0];
                REG_OBS_SCALE:  obs_scale_reg  <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sample FIFO in RAM, oldest entry at the read pointer.
    logic [A_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [SAMPLE_W-1:0] oldest;

    tws_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN)) u_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (wr_ptr_reg),
        .wdata (sample),
        .re    (cmd.level),
        .raddr (rd_ptr_reg),
        .rdata (oldest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.insert)
            begin
                wr_ptr_reg <= (wr_ptr_reg == A_W'(WIN - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd.del)
            begin
                rd_ptr_reg <= (rd_ptr_reg == A_W'(WIN - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Sorted cells, ascending; valid bits form a prefix and count the held samples.
    logic [SAMPLE_W-1:0] cell_reg [WIN];
    logic [SAMPLE_W-1:0] cell_next [WIN];
    logic [WIN-1:0]      vld_reg, vld_next;
    logic [WIN-1:0]      gt_new, ge_old;

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            gt_new[i] = !vld_reg[i] || (cell_reg[i] > sample);
            ge_old[i] = vld_reg[i] && (cell_reg[i] >= oldest);
        end
        vld_next = vld_reg;
        for (int i = 0; i < WIN; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.insert)
        begin
            vld_next = {vld_reg[WIN-2:0], 1'b1} | vld_reg;
            for (int i = 0; i < WIN; i++)
            begin
                if (gt_new[i])
                begin
                    if (i > 0 && gt_new[(i > 0) ? i - 1 : 0])
                    begin
                        cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        cell_next[i] = sample;
                    end
                end
            end
        end
        else if (cmd.del)
        begin
            vld_next = {1'b0, vld_reg[WIN-1:1]};
            for (int i = 0; i < WIN - 1; i++)
            begin
                if (ge_old[i])
                begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Running total of the held samples.
    logic [TOT_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (cmd.insert)
        begin
            total_reg <= total_reg + TOT_W'(sample);
        end
        else if (cmd.del)
        begin
            total_reg <= total_reg - TOT_W'(oldest);
        end
    end

    // Trimmed extremes are copied into a shift line and summed one a cycle.
    logic [SAMPLE_W-1:0] tline_reg [TLEN];
    logic [TOT_W-1:0]    acc_reg;
    logic [K_W-1:0]      k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (TRIM == 0)
            begin
                tline_reg[0] <= '0;
            end
            else
            begin
                for (int k = 0; k < TRIM; k++)
                begin
                    tline_reg[k]        <= cell_reg[k];
                    tline_reg[TRIM + k] <= cell_reg[WIN - 1 - k];
                end
            end
            acc_reg <= '0;
            k_reg   <= '0;
        end
        else if (cmd.tacc)
        begin
            acc_reg <= acc_reg + TOT_W'(tline_reg[0]);
            for (int k = 0; k < TLEN - 1; k++)
            begin
                tline_reg[k] <= tline_reg[k+1];
            end
            k_reg <= k_reg + 1'b1;
        end
    end

    // Level, bias correction and divider operands.
    logic [SAMPLE_W-1:0] level_reg;
    logic [TOT_W-1:0]    kept_sum;
    logic [SAMPLE_W-1:0] biased;
    logic [BIAS_W:0]     bias_sum;
    logic [16:0]         rem_reg;
    logic [OBS_W-1:0]    quo_reg;
    logic [SCALE_W-1:0]  divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [16:0]         shifted, trial;

    assign kept_sum = total_reg - acc_reg;
    assign bias_sum = (BIAS_W + 1)'(level_reg) + (BIAS_W + 1)'(bias_mag_reg);

    always_comb
    begin
        if (!obs_enable_reg)
        begin
            biased = level_reg;
        end
        else if (bias_neg_reg)
        begin
            biased = (bias_sum > (BIAS_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : bias_sum[SAMPLE_W-1:0];
        end
        else if (BIAS_W'(level_reg) > bias_mag_reg)
        begin
            biased = level_reg - bias_mag_reg[SAMPLE_W-1:0];
        end
        else
        begin
            biased = '0;
        end
    end

    assign shifted = {rem_reg[15:0], quo_reg[OBS_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.level)
        begin
            level_reg <= SAMPLE_W'(kept_sum >> KEPT_LOG2);
        end
        else if (cmd.bias)
        begin
            level_reg   <= biased;
            rem_reg     <= '0;
            quo_reg     <= {biased, 4'b0000};
            divisor_reg <= (obs_scale_reg == '0) ? SCALE_W'(1) : obs_scale_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[OBS_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[OBS_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Output register.
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_level_reg;
    logic [OBS_W-1:0]    out_obs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_level_reg <= level_reg;
            out_obs_reg   <= obs_enable_reg ? quo_reg : '0;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.smoke_level = out_level_reg;
    assign results.obs_value   = out_obs_reg;

    // Status to the controller.
    assign sts.will_fill = vld_reg[WIN-2];
    assign sts.tacc_last = (k_reg == K_W'(TLEN - 1));
    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(OBS_W - 1));
    assign sts.obs_en    = obs_enable_reg;
    assign sts.out_busy  = out_valid_reg;

`ifndef ASSERT_OFF
    // A new sample never arrives with the window already full.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !vld_reg[WIN-1])
        else $error("sample inserted into a full window");

    // After the oldest sample leaves, the top cell is empty.
    a_del_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |=> !vld_reg[WIN-1])
        else $error("top cell still valid after delete");

    // A result is loaded only into an empty output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result overwrote a waiting result");

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |-> (rem_reg < {1'b0, divisor_reg}))
        else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

@@ src/trimmed_window_smoke_obscuration.sv @@
// Top level of the trimmed window smoke filter with obscuration output.
//
//  channel   | dir | fields                   | handshake
//  ----------+-----+--------------------------+-------------------
//  samples   | in  | sample[11:0]             | valid/ready
//  results   | out | smoke_level, obs_value   | valid/ready
//  cfg       | in  | cfg_we, cfg_index, data  | write enable only
//
// While the window fills, each item is taken as soon as it is offered. Once full, each
// item goes through the load, trim-sum, level, delete and bias steps, the one-bit-a-cycle serial
// divider when obscuration is enabled, then the output step, before a new item is taken.
// Reset clears the control state, the fill state and the configuration.
// A finished result waits in the output register and the next item is still taken;
// if it has not left when the next result is ready, no further item is taken until it does.
`default_nettype none
module trimmed_window_smoke_obscuration #(
    parameter int TRIM      = 4,
    parameter int KEPT_LOG2 = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tws_sample_if.sink                          samples,
    tws_result_if.source                        results,
    input  wire logic                           cfg_we,
    input  wire logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tws_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tws_dp #(.TRIM(TRIM), .KEPT_LOG2(KEPT_LOG2)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (samples.sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .results   (results)
    );

endmodule
`default_nettype wire

@@ tb/sv/tws_checker.sv @@
// Checker that predicts and compares the filter's results by watching its channels.
`timescale 1ns / 100ps
module tws_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    tws_sample_if                          samples,
    tws_result_if                          results,
    input  logic                           cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             checked
);
    import tws_pkg::*;

    localparam int TRIM_N   = 4;
    localparam int KEPT_SH  = 5;
    localparam int WIN_LEN  = 2 * TRIM_N + (1 << KEPT_SH);

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoke_level;
        logic [OBS_W-1:0]    obs_value;
    } reading_t;

    // Shadow copy of the configuration registers.
    logic                obs_on;
    logic [BIAS_W-1:0]   bias_mag;
    logic                bias_neg;
    logic [SCALE_W-1:0]  scale;

    logic [SAMPLE_W-1:0] window_q[$];
    reading_t            reading_q[$];

    // Rank the window, drop the trimmed ends, average, then correct and scale.
    function automatic reading_t filter_window();
        logic [SAMPLE_W-1:0] ranked[WIN_LEN];
        logic [SAMPLE_W-1:0] x;
        int                  j;
        int unsigned         sum;
        int unsigned         level;
        int unsigned         div;
        reading_t            r;
        for (int i = 0; i < WIN_LEN; i++)
            ranked[i] = window_q[i];
        for (int i = 1; i < WIN_LEN; i++)
        begin
            x = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > x)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = x;
        end
        sum = 0;
        for (int i = TRIM_N; i < WIN_LEN - TRIM_N; i++)
            sum += ranked[i];
        level = sum >> KEPT_SH;
        r.obs_value = '0;
        if (obs_on)
        begin
            if (bias_neg)
                level = (level + bias_mag > 4095) ? 4095 : level + bias_mag;
            else
                level = (level > bias_mag) ? level - bias_mag : 0;
            div = (scale == 0) ? 1 : scale;
            r.obs_value = OBS_W'((level << 4) / div);
        end
        r.smoke_level = SAMPLE_W'(level);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t exp_r;
        if (!rst_n)
        begin
            obs_on      <= 1'b0;
            bias_mag    <= '0;
            bias_neg    <= 1'b0;
            scale       <= SCALE_W'(1);
            window_q.delete();
            reading_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            // Register writes take only the bits each register holds.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OBS_ENABLE: obs_on   <= cfg_data[0];
                    REG_BIAS_MAG:   bias_mag <= cfg_data[BIAS_W-1:0];
                    REG_BIAS_NEG:   bias_neg <= cfg_data[0];
                    REG_OBS_SCALE:  scale    <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            // Compare each result item with the oldest expected reading.
            if (results.valid && results.ready)
            begin
                checked <= checked + 1;
                if (reading_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: level %0d obs %0d",
                                 results.smoke_level, results.obs_value);
                end
                else
                begin
                    exp_r = reading_q.pop_front();
                    if (exp_r.smoke_level !== results.smoke_level
                        || exp_r.obs_value !== results.obs_value)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: level exp %0d got %0d, obs exp %0d got %0d",
                                     exp_r.smoke_level, results.smoke_level,
                                     exp_r.obs_value, results.obs_value);
                    end
                end
            end

            // A full window turns each new sample item into one reading.
            if (samples.valid && samples.ready)
            begin
                window_q.push_back(samples.sample);
                if (window_q.size() == WIN_LEN)
                begin
                    reading_q.push_back(filter_window());
                    void'(window_q.pop_front());
                end
            end
            outstanding <= reading_q.size();
        end
    end
endmodule

@@ tb/sv/tb_top.sv @@
// Top of the testbench: stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
    import tws_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 64;
    localparam int PHASE_ITEMS = 225;
    localparam int NUM_PHASES  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  quiet;
    int                    mismatches;
    int                    outstanding;
    int                    checked;
    int                    sent;
    int                    idle_cycles;

    tws_sample_if sample_ch();
    tws_result_if result_ch();

    trimmed_window_smoke_obscuration DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tws_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Result side: stall randomly before taking each item, except in quiet phases.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Offer one sample item after a random gap (none in quiet phases); returns at the falling edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sent++;
        @(negedge clk);
    endtask

    // Let every reading drain, then the block settle, before touching registers.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] mag,
                              input logic [CFG_DATA_W-1:0] neg, input logic [CFG_DATA_W-1:0] scl);
        cfg_we <= 1'b1; cfg_index <= REG_OBS_ENABLE; cfg_data <= en;
        @(negedge clk);
        cfg_index <= REG_BIAS_MAG; cfg_data <= mag;
        @(negedge clk);
        cfg_index <= REG_BIAS_NEG; cfg_data <= neg;
        @(negedge clk);
        cfg_index <= REG_OBS_SCALE; cfg_data <= scl;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mix of extremes, a wandering cluster and uniform values.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int center);
        int sel;
        int v;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
        if (sel <= 3)
        begin
            v = center + $urandom_range(0, 400) - 200;
            return SAMPLE_W'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
        end
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    initial
    begin
        int center;
        logic [CFG_DATA_W-1:0] en, mag, neg, scl;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        quiet = 1'b0;
        sent = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed fill: extremes, walking ones and walking zeros, no reading until the window is full.
        write_regs(16'd0, 16'd0, 16'd0, 16'd1);
        send_sample(12'd0);
        send_sample(12'd4095);
        for (int k = 0; k < SAMPLE_W; k++)
        begin
            send_sample(SAMPLE_W'(1) << k);
            send_sample(~(SAMPLE_W'(1) << k));
        end
        while (sent < 44)
            send_sample(($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0);

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0: begin en = 1; mag = 0; neg = 0; scl = 1; end
                1: begin en = 1; mag = 16'hFFFF; neg = 1; scl = 16'hFFFF; end
                2: begin en = 1; mag = 16'h7FFF; neg = 0; scl = 0; end
                3: begin en = 16'hFFFE; mag = 100; neg = 16'hFFFF; scl = 3; end
                4: begin en = 1; mag = $urandom_range(0, 4095); neg = $urandom_range(0, 1);
                         scl = $urandom_range(1, 65535); end
                5: begin en = 1; mag = $urandom_range(0, 300); neg = 1; scl = 0; end
                6: begin en = 0; mag = $urandom_range(0, 65535); neg = 0; scl = 7; end
                default: begin en = 1; mag = $urandom_range(0, 400); neg = 0;
                               scl = $urandom_range(1, 40); end
            endcase
            write_regs(en, mag, neg, scl);
            quiet = (p % 3 == 0);
            center = $urandom_range(0, 4095);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 31) == 0)
                    center = $urandom_range(0, 4095);
                send_sample(pick_sample(center));
            end
        end

        drain();
        $display("Sent %0d smoke samples over %0d register settings; %0d readings checked.",
                 sent, NUM_PHASES + 1, checked);
        $display("Covered window fill, bias saturation and floor, zero and extreme scales.");
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
src/tws_pkg.sv
src/tws_sample_if.sv
src/tws_result_if.sv
src/tws_ram.sv
src/tws_ctrl.sv
src/tws_dp.sv
src/trimmed_window_smoke_obscuration.sv
tb/sv/tws_checker.sv
tb/sv/tb_top.sv
